[rtl/amq_pkg.sv]
// ----------------------------------------------------------------------------
// amq_pkg: shared types and constants for the absmax int8 quant scale block
// Float constants, controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package amq_pkg;

  localparam logic [31:0] OneBits  = 32'h3F80_0000;
  localparam logic [31:0] TinyBits = 32'h33D6_BF95; // 1e-7f
  localparam logic [23:0] SigN127  = 24'hFE_0000;   // 127.0 significand
  localparam int unsigned QuoW     = 27;            // 24 bits + guard + round + extra
  localparam int unsigned CntW     = 5;
  localparam int unsigned DqSteps  = 5;             // shift-add steps, times (2^42-1)/127
  localparam int unsigned AccW     = 69;            // 33-bit dividend times 36-bit factor

  typedef struct packed {
    logic merge;   // merge input word into running max
    logic start;   // load divider operands from running max
    logic step;    // one quotient bit for 127/max, and in the first DqSteps steps one shift-add for max/127
    logic finish;  // round and load output register
    logic clr;     // running max back to +0.0
  } amq_cmd_t;

  typedef struct packed {
    logic div_done;
  } amq_sts_t;

endpackage

[rtl/absmax_int8_quant_scale.sv]
// Result: a last word's scales appear after operand load, 27 divide steps, one done
// check and rounding; other words give no result.
// Input: one word per cycle within a group; after a last word the input stalls
// through the divide and rounding, and longer while the previous result is still stalled.
// Reset: asynchronous active low; running maximum returns to +0.0, no result pending.
// ----------------------------------------------------------------------------
// absmax_int8_quant_scale: int8 absmax quantization scale
// Running maxNum over binary32 words, then 127/max and max/127 per group.
// ----------------------------------------------------------------------------
module absmax_int8_quant_scale (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] partial_max_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] qscale_o,
  output logic [31:0] dqscale_o
);

  amq_pkg::amq_cmd_t cmd;
  amq_pkg::amq_sts_t sts;

  amq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .last_i,
    .out_valid_o, .out_stall_i, .cmd_o(cmd), .sts_i(sts)
  );

  amq_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .partial_max_i,
    .qscale_o, .dqscale_o
  );

endmodule

[rtl/amq_dp.sv]
// ----------------------------------------------------------------------------
// amq_dp: datapath
// Running maxNum, restoring divider for 127/max, shift-add reciprocal of 127
// for max/127, rounding.
// ----------------------------------------------------------------------------
module amq_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  amq_pkg::amq_cmd_t   cmd_i,
  output amq_pkg::amq_sts_t   sts_o,
  input  logic [31:0]         partial_max_i,
  output logic [31:0]         qscale_o,
  output logic [31:0]         dqscale_o
);

  localparam logic [amq_pkg::CntW-1:0] HornerEnd =
    amq_pkg::CntW'(amq_pkg::QuoW - amq_pkg::DqSteps);

  logic [31:0] max_q, max_d;
  logic        in_nan, in_gt;
  logic        spec_q;          // tiny or inf max, no division needed
  logic [31:0] spec_q_val_q, spec_d_val_q;
  logic [8:0]  qexp_q, dexp_q;  // biased result exponents (signed-ish, 9 bits)
  logic [24:0] qrem_q;
  logic [23:0] msig_q;
  logic [amq_pkg::QuoW-1:0] qquo_q, dquo_q;
  logic [amq_pkg::AccW-1:0] dacc_q;
  logic [amq_pkg::AccW-1:0] dnum;
  logic                     dstk_q;
  logic [amq_pkg::QuoW-1:0] dq_est;
  logic [7:0]               dq_res;
  logic                     dq_exact;
  logic [amq_pkg::CntW-1:0] cnt_q;
  logic [31:0] qs_q, ds_q;

  assign in_nan = (partial_max_i[30:23] == 8'hFF) && (partial_max_i[22:0] != 23'd0);
  // max is >= +0.0 so an ordered compare on magnitude bits works for positives
  assign in_gt  = !partial_max_i[31] && (partial_max_i[30:0] > max_q[30:0]);

  always_comb begin
    max_d = max_q;
    if (cmd_i.clr) begin
      max_d = '0;
    end else if (cmd_i.merge && !in_nan && in_gt) begin
      max_d = partial_max_i;
    end
  end

  // operand prep
  logic        m_tiny, m_inf;
  logic [23:0] m_sig;
  logic [8:0]  m_exp;
  assign m_tiny = max_q[30:0] < amq_pkg::TinyBits[30:0];
  assign m_inf  = max_q[30:23] == 8'hFF;
  always_comb begin
    if (max_q[30:23] == 8'd0) begin
      m_sig = {1'b0, max_q[22:0]};
      m_exp = 9'd1;
    end else begin
      m_sig = {1'b1, max_q[22:0]};
      m_exp = {1'b0, max_q[30:23]};
    end
  end

  // max/127: n = sig << 9, floor(n*(2^42-1)/127 >> 42) is floor(n/127) or one less;
  // it is one less exactly when 127 divides n, seen from the low byte of n - 127*est
  assign dnum     = amq_pkg::AccW'({msig_q, 9'd0});
  assign dq_est   = dacc_q[amq_pkg::AccW-1 -: amq_pkg::QuoW];
  assign dq_res   = dq_est[7:0] - {dq_est[0], 7'd0};
  assign dq_exact = (dq_res == 8'h7F);

  // rounding: quotient has 27 bits, msb at 26 or 25
  function automatic logic [31:0] amq_round(input logic [amq_pkg::QuoW-1:0] quo,
                                            input logic sticky,
                                            input logic [8:0] e);
    logic [23:0] sig;
    logic        g, s;
    logic [8:0]  ex;
    logic [24:0] r;
    if (quo[26]) begin
      sig = quo[26:3]; g = quo[2]; s = |quo[1:0] | sticky; ex = e;
    end else begin
      sig = quo[25:2]; g = quo[1]; s = quo[0] | sticky; ex = e - 9'd1;
    end
    r = {1'b0, sig} + {24'd0, g & (s | sig[0])};
    if (r[24]) begin
      ex = ex + 9'd1;
      r  = r >> 1;
    end
    return {1'b0, ex[7:0], r[22:0]};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
      cnt_q <= '0;
    end else begin
      max_q <= max_d;
      if (cmd_i.start) begin
        cnt_q <= amq_pkg::CntW'(amq_pkg::QuoW);
      end else if (cmd_i.step && cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      spec_q <= m_tiny || m_inf;
      spec_q_val_q <= m_tiny ? amq_pkg::OneBits : 32'h0000_0000;
      spec_d_val_q <= m_tiny ? amq_pkg::OneBits : 32'h7F80_0000;
      msig_q <= m_sig;
      // 127/m: exponent 133-e+127 ; quo msb weight 2^(ea-eb), at bit 26 -> +0
      qexp_q <= 9'd133 - m_exp + 9'd127;
      dexp_q <= m_exp - 9'd133 + 9'd127;
      qrem_q <= {1'b0, amq_pkg::SigN127};
      qquo_q <= '0;
      dacc_q <= amq_pkg::AccW'({m_sig, 9'd0});
      dquo_q <= '0;
      dstk_q <= 1'b0;
    end else if (cmd_i.step && cnt_q != '0) begin
      if (qrem_q >= {1'b0, msig_q}) begin
        qrem_q <= (qrem_q - {1'b0, msig_q}) << 1;
        qquo_q <= {qquo_q[amq_pkg::QuoW-2:0], 1'b1};
      end else begin
        qrem_q <= qrem_q << 1;
        qquo_q <= {qquo_q[amq_pkg::QuoW-2:0], 1'b0};
      end
      if (cnt_q > HornerEnd) begin
        dacc_q <= (dacc_q << 7) + dnum;
      end
      if (cnt_q == amq_pkg::CntW'(1)) begin
        dquo_q <= dq_est + amq_pkg::QuoW'(dq_exact);
        dstk_q <= !dq_exact;
      end
    end
    if (cmd_i.finish) begin
      if (spec_q) begin
        qs_q <= spec_q_val_q;
        ds_q <= spec_d_val_q;
      end else begin
        qs_q <= amq_round(qquo_q, qrem_q != '0, qexp_q);
        ds_q <= amq_round(dquo_q, dstk_q, dexp_q);
      end
    end
  end

  assign sts_o.div_done = (cnt_q == '0);
  assign qscale_o       = qs_q;
  assign dqscale_o      = ds_q;

endmodule

[rtl/amq_ctrl.sv]
// ----------------------------------------------------------------------------
// amq_ctrl: controller
// Accepts words, sequences the divide on a last word, owns the output handshake.
// ----------------------------------------------------------------------------
module amq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output amq_pkg::amq_cmd_t cmd_o,
  input  amq_pkg::amq_sts_t sts_i
);

  typedef enum logic [1:0] {ST_IDLE, ST_START, ST_DIV, ST_FIN} state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   in_acc;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    cmd_o        = '0;
    cmd_o.merge  = in_acc;
    cmd_o.start  = (state_q == ST_START);
    cmd_o.step   = (state_q == ST_DIV);
    cmd_o.finish = (state_q == ST_FIN) && !(out_valid_q && out_stall_i);
    cmd_o.clr    = cmd_o.finish;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE:  if (in_acc && last_i) state_q <= ST_START;
        ST_START: state_q <= ST_DIV;
        ST_DIV:   if (sts_i.div_done) state_q <= ST_FIN;
        ST_FIN: begin
          if (cmd_o.finish) begin
            state_q <= ST_IDLE;
          end
        end
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/amq_checker.sv]
// ----------------------------------------------------------------------------
// amq_checker: port-level checks
// Output handshake, input stall and result-after-group-end checks.
// ----------------------------------------------------------------------------
module amq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        last_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] qscale_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(qscale_o))
    else $error("stalled result changed");

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i |=> in_stall_o)
    else $error("word taken during divide");

  a_nonlast_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !last_i |=> !in_stall_o)
    else $error("stall after plain word");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without group end");

endmodule

bind absmax_int8_quant_scale amq_checker u_amq_checker (.*);

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: absmax int8 quant scale block
// A directed table is sent first, then about 2000 random words in groups.
// Each accepted word updates a running maxNum, and each group yields one
// expected 127/max and max/127 pair, rounded to nearest even. Results are
// compared in order against these pairs. Both sides stall at random.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [31:0] pm;
    logic        last;
    logic        typed;
    logic [31:0] q;
    logic [31:0] d;
  } row_t;

  typedef struct packed {
    logic [31:0] q;
    logic [31:0] d;
  } scales_t;

  localparam int unsigned NumRand  = 2000;
  localparam int unsigned MaxCycle = 1_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] partial_max_i = '0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [31:0] qscale_o;
  logic [31:0] dqscale_o;

  logic [31:0] group_max = '0;
  scales_t     scale_q[$];
  int unsigned errs = 0;
  int unsigned cycles = 0;
  bit          hold_rx = 1'b0;
  bit          no_gaps = 1'b0;

  absmax_int8_quant_scale u_dut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MaxCycle) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // binary32 divide of two positive normals, result known to be normal
  function automatic logic [31:0] fdiv(logic [31:0] a, logic [31:0] b);
    logic [50:0] num;
    logic [50:0] quo;
    logic [50:0] rem;
    logic [24:0] mant;
    logic        grd;
    logic        stk;
    int          ex;
    num = {3'b0, 1'b1, a[22:0]} << 26;
    quo = num / {1'b1, b[22:0]};
    rem = num % {1'b1, b[22:0]};
    ex  = int'(a[30:23]) - int'(b[30:23]) + 127;
    if (quo[26]) begin
      mant = {1'b0, quo[26:3]};
      grd  = quo[2];
      stk  = |quo[1:0] || rem != 0;
    end else begin
      mant = {1'b0, quo[25:2]};
      grd  = quo[1];
      stk  = quo[0] || rem != 0;
      ex--;
    end
    if (grd && (stk || mant[0])) mant++;
    if (mant[24]) begin
      mant = mant >> 1;
      ex++;
    end
    return {1'b0, ex[7:0], mant[22:0]};
  endfunction

  // running maxNum; returns 1 with the scales when the group closes
  function automatic bit absmax_step(logic [31:0] pm, logic lst, output scales_t s);
    bit is_nan;
    is_nan = &pm[30:23] && |pm[22:0];
    if (!is_nan && !pm[31] && pm > group_max) group_max = pm;
    if (!lst) return 1'b0;
    if (group_max < amq_pkg::TinyBits) s = '{amq_pkg::OneBits, amq_pkg::OneBits};
    else if (group_max == 32'h7F80_0000) s = '{32'h0, 32'h7F80_0000};
    else s = '{fdiv(32'h42FE_0000, group_max), fdiv(group_max, 32'h42FE_0000)};
    group_max = '0;
    return 1'b1;
  endfunction

  task automatic send_word(logic [31:0] pm, logic lst, bit typed, scales_t want);
    scales_t s;
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(17);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    partial_max_i <= pm;
    last_i        <= lst;
    do @(posedge clk_i); while (in_stall_o);
    if (absmax_step(pm, lst, s)) scale_q.push_back(typed ? want : s);
  endtask

  function automatic logic [31:0] rand_word();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 60) return {1'b0, 8'($urandom_range(254, 90)), 23'($urandom)};
    if (k < 68) return {1'b0, 8'($urandom_range(110, 100)), 23'($urandom)};
    if (k < 74) return {1'b1, 31'($urandom)};
    if (k < 78) return {1'b0, 8'hFF, 23'($urandom) | 23'h1};
    if (k < 80) return 32'h7F80_0000;
    if (k < 84) return {9'b0, 23'($urandom)};
    return $urandom;
  endfunction

  initial begin : stim
    row_t dir[] = '{
      '{32'h0000_0000, 1'b1, 1'b1, amq_pkg::OneBits, amq_pkg::OneBits},
      '{32'h42FE_0000, 1'b1, 1'b1, amq_pkg::OneBits, amq_pkg::OneBits},
      '{32'h3F80_0000, 1'b1, 1'b0, 32'h0, 32'h0},
      '{32'h7F80_0000, 1'b1, 1'b1, 32'h0, 32'h7F80_0000},
      '{32'h7F7F_FFFF, 1'b1, 1'b0, 32'h0, 32'h0},
      '{32'h0000_0001, 1'b1, 1'b1, amq_pkg::OneBits, amq_pkg::OneBits},
      '{32'h33D6_BF94, 1'b1, 1'b1, amq_pkg::OneBits, amq_pkg::OneBits},
      '{32'h33D6_BF95, 1'b1, 1'b0, 32'h0, 32'h0},
      '{32'h7FC0_0000, 1'b0, 1'b0, 32'h0, 32'h0},
      '{32'hBF80_0000, 1'b0, 1'b0, 32'h0, 32'h0},
      '{32'h8000_0000, 1'b1, 1'b1, amq_pkg::OneBits, amq_pkg::OneBits},
      '{32'h4000_0000, 1'b0, 1'b0, 32'h0, 32'h0},
      '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 32'h0},
      '{32'h3F00_0000, 1'b0, 1'b0, 32'h0, 32'h0},
      '{32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 32'h0},
      '{32'h0080_0000, 1'b1, 1'b1, amq_pkg::OneBits, amq_pkg::OneBits}
    };
    int unsigned sent;
    int unsigned glen;
    int unsigned waited;
    int unsigned next_mix;
    bit          held;
    bit          drained;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir[i]) begin
      send_word(dir[i].pm, dir[i].last, dir[i].typed, scales_t'{dir[i].q, dir[i].d});
    end
    sent     = 0;
    next_mix = 0;
    held     = 1'b0;
    drained  = 1'b0;
    while (sent < NumRand) begin
      if (sent >= next_mix) begin
        no_gaps = 1'($urandom_range(1));
        next_mix += 250;
      end
      if (!held && sent >= 600) begin
        hold_rx = 1'b1;
        held    = 1'b1;
      end
      if (!drained && sent >= 1200) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        wait (scale_q.size() == 0);
        drained = 1'b1;
      end
      glen = $urandom_range(9, 1);
      for (int unsigned j = 0; j < glen; j++) send_word(rand_word(), j == glen - 1, 0, '0);
      sent += glen;
    end
    in_valid_i <= 1'b0;
    waited = 0;
    while (scale_q.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (64) @(posedge clk_i);
    if (errs == 0 && scale_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : rx
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      n = $urandom_range(3) == 0 ? 0 : $urandom_range(17);
      if (hold_rx) begin
        hold_rx = 1'b0;
        n = 400;
      end
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    scales_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (scale_q.size() == 0) begin
        $display("%0t: unexpected word exp none got q=%h d=%h", $time, qscale_o, dqscale_o);
        errs++;
      end else begin
        want = scale_q.pop_front();
        if (qscale_o !== want.q) begin
          $display("%0t: qscale exp %h got %h", $time, want.q, qscale_o);
          errs++;
        end
        if (dqscale_o !== want.d) begin
          $display("%0t: dqscale exp %h got %h", $time, want.d, dqscale_o);
          errs++;
        end
      end
    end
  end

endmodule

[absmax_int8_quant_scale.f]
rtl/amq_pkg.sv
rtl/amq_dp.sv
rtl/amq_ctrl.sv
rtl/absmax_int8_quant_scale.sv
rtl/amq_checker.sv
dv/testbench.sv
